/* hw/rtl/jsd_pkg.sv */
// Shared types and constants for the JSON string decoder.
// Holds the decoder state record, the result record and the character codes.
// No dependencies.
package jsd_pkg;

   // decoded-string capacity and the width of the length field
   localparam int unsigned STRING_CAPACITY = 96;
   localparam int unsigned LEN_W           = 7;

   // one input item gives at most four decoded bytes and one status
   localparam int unsigned MAX_BYTES   = 4;
   localparam int unsigned MAX_RESULTS = MAX_BYTES + 1;
   localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS + 1);

   // result queue between the decoder and the rsp channel
   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_SLASH  = 8'h2f;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6e;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_U      = 8'h75;

   typedef enum logic [9:0] {
      MODE_IDLE      = 10'b00_0000_0001,
      MODE_BODY      = 10'b00_0000_0010,
      MODE_ESC       = 10'b00_0000_0100,
      MODE_HEX1      = 10'b00_0000_1000,
      MODE_SURR_BS   = 10'b00_0001_0000,
      MODE_SURR_U    = 10'b00_0010_0000,
      MODE_HEX2      = 10'b00_0100_0000,
      MODE_U8_SECOND = 10'b00_1000_0000,
      MODE_U8_REST   = 10'b01_0000_0000,
      MODE_DONE      = 10'b10_0000_0000
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_CLOSED = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MALFORMED = 2'd1,
      ERR_UTF8      = 2'd2
   } err_type;

   typedef struct packed {
      mode_type         mode;
      logic [15:0]      hex_accum;
      logic [1:0]       hex_count;
      logic [9:0]       high_surrogate;
      logic [23:0]      utf8_bytes;
      logic [1:0]       utf8_remaining;
      logic [2:0]       seq_len;
      logic [LEN_W-1:0] byte_count;
      logic             trunc;
      logic             null_seen;
   } state_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      err_type          err;
      logic [LEN_W-1:0] length;
      logic             trunc;
      logic             null_seen;
      logic             last;
   } result_type;

   localparam state_type STATE_RESET = '{mode: MODE_IDLE, default: '0};

endpackage

/* hw/rtl/json_string_decoder_unit.sv */
// An accepted item's results are registered into the result queue and offered on rsp
// from its head, oldest first. Throughput: one item per cycle while each item gives
// at most one result and rsp_stall is low; an item giving several (up to four bytes
// and a status) drains one result per cycle, while rsp_stall is low, through an
// eight-entry queue; req_stall rises while it holds more than three. Synchronous
// active-high reset idles the decoder (awaiting the opening quote) and clears the queue.
module json_string_decoder_unit (
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_in_byte,
   input  logic                      req_start_flag,
   input  logic                      req_final_flag,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_result_kind,
   output logic [7:0]                rsp_out_byte,
   output logic [1:0]                rsp_error_kind,
   output logic [jsd_pkg::LEN_W-1:0] rsp_decoded_length,
   output logic                      rsp_was_truncated,
   output logic                      rsp_saw_null,
   output logic                      rsp_last_of_run
);

   // Decoder state: updated once per accepted item.
   jsd_pkg::state_type  state_ff;
   jsd_pkg::state_type  state_in;
   jsd_pkg::result_type step_results [jsd_pkg::MAX_RESULTS];
   logic [jsd_pkg::RES_IDX_W-1:0] step_count;

   // Result queue: every result of an item is written in the accepting cycle.
   jsd_pkg::result_type queue_ff [jsd_pkg::QUEUE_DEPTH];
   logic [jsd_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [jsd_pkg::QPTR_W-1:0] wr_ptr_in;
   logic [jsd_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [jsd_pkg::QPTR_W-1:0] rd_ptr_in;
   logic [jsd_pkg::QCNT_W-1:0] count_ff;
   logic [jsd_pkg::QCNT_W-1:0] count_in;
   logic [jsd_pkg::QCNT_W-1:0] push_count;

   logic                req_take;
   logic                rsp_take;
   jsd_pkg::result_type head;

   jsd_step u_step (
      .cur_state    (state_ff),
      .in_byte      (req_in_byte),
      .start_flag   (req_start_flag),
      .final_flag   (req_final_flag),
      .next_state   (state_in),
      .results      (step_results),
      .result_count (step_count)
   );

   // Stall unless the queue can take a full burst of results.
   assign req_stall = (count_ff >
                       jsd_pkg::QCNT_W'(jsd_pkg::QUEUE_DEPTH - jsd_pkg::MAX_RESULTS));
   assign req_take  = req_valid & ~req_stall;

   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid & ~rsp_stall;

   always_comb begin
      push_count = req_take ? jsd_pkg::QCNT_W'(step_count) : '0;
      wr_ptr_in  = wr_ptr_ff + jsd_pkg::QPTR_W'(push_count);
      rd_ptr_in  = rd_ptr_ff + jsd_pkg::QPTR_W'(rsp_take);
      count_in   = count_ff + push_count - jsd_pkg::QCNT_W'(rsp_take);
   end

   // Control: decoder state and queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= jsd_pkg::STATE_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload: write the item's results at consecutive queue slots.
   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int k = 0; k < jsd_pkg::MAX_RESULTS; k++) begin
            if (jsd_pkg::RES_IDX_W'(k) < step_count) begin
               queue_ff[wr_ptr_ff + jsd_pkg::QPTR_W'(k)] <= step_results[k];
            end
         end
      end
   end

   // Present the oldest result.
   assign head               = queue_ff[rd_ptr_ff];
   assign rsp_result_kind    = head.kind;
   assign rsp_out_byte       = head.data;
   assign rsp_error_kind     = head.err;
   assign rsp_decoded_length = head.length;
   assign rsp_was_truncated  = head.trunc;
   assign rsp_saw_null       = head.null_seen;
   assign rsp_last_of_run    = head.last;

endmodule

/* hw/rtl/jsd_step.sv */
// Next-state and result logic of the JSON string decoder for one input byte.
// Purely combinational; uses jsd_pkg for the state and result records.
module jsd_step (
   input  jsd_pkg::state_type  cur_state,
   input  logic [7:0]          in_byte,
   input  logic                start_flag,
   input  logic                final_flag,
   output jsd_pkg::state_type  next_state,
   output jsd_pkg::result_type results [jsd_pkg::MAX_RESULTS],
   output logic [jsd_pkg::RES_IDX_W-1:0] result_count
);

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b1, 4'(c - 8'h37)};
      end
      return v;
   endfunction

   jsd_pkg::state_type st;
   jsd_pkg::state_type nxt;
   logic [7:0]         cand [jsd_pkg::MAX_BYTES];
   logic [2:0]         nb;
   logic               has_status;
   jsd_pkg::kind_type  st_kind;
   jsd_pkg::err_type   st_err;
   logic [4:0]         hv;
   logic [15:0]        acc_next;
   logic               hex_done;
   logic [20:0]        cp21;
   logic [7:0]         lead;
   logic [7:0]         lo_bound;
   logic [7:0]         hi_bound;
   logic [jsd_pkg::LEN_W-1:0] room;
   logic [2:0]         emit;
   logic [jsd_pkg::RES_IDX_W-1:0] cnt;

   always_comb begin
      st         = start_flag ? jsd_pkg::STATE_RESET : cur_state;
      nxt        = st;
      nb         = '0;
      has_status = 1'b0;
      st_kind    = jsd_pkg::KIND_CLOSED;
      st_err     = jsd_pkg::ERR_NONE;
      for (int i = 0; i < jsd_pkg::MAX_BYTES; i++) begin
         cand[i] = '0;
      end
      hv       = hex_value(in_byte);
      acc_next = {st.hex_accum[11:0], hv[3:0]};
      hex_done = (st.hex_count == 2'd3);
      cp21     = 21'h10000 + {1'b0, st.high_surrogate, acc_next[9:0]};
      lead     = st.utf8_bytes[7:0];
      lo_bound = 8'h80;
      hi_bound = 8'hbf;
      if (lead == 8'he0) begin
         lo_bound = 8'ha0;
      end else if (lead == 8'hed) begin
         hi_bound = 8'h9f;
      end else if (lead == 8'hf0) begin
         lo_bound = 8'h90;
      end else if (lead == 8'hf4) begin
         hi_bound = 8'h8f;
      end

      unique case (st.mode)
         jsd_pkg::MODE_IDLE: begin
            if (in_byte == jsd_pkg::CHAR_QUOTE) begin
               nxt.mode = jsd_pkg::MODE_BODY;
            end else begin
               has_status = 1'b1;
               st_kind    = jsd_pkg::KIND_ERROR;
               st_err     = jsd_pkg::ERR_MALFORMED;
            end
         end
         jsd_pkg::MODE_BODY: begin
            priority if (in_byte == jsd_pkg::CHAR_QUOTE) begin
               has_status = 1'b1;
            end else if (in_byte == jsd_pkg::CHAR_BSLASH) begin
               nxt.mode = jsd_pkg::MODE_ESC;
            end else if (in_byte < 8'h20) begin
               has_status = 1'b1;
               st_kind    = jsd_pkg::KIND_ERROR;
               st_err     = jsd_pkg::ERR_MALFORMED;
            end else if (in_byte < 8'h80) begin
               cand[0] = in_byte;
               nb      = 3'd1;
            end else if (in_byte >= 8'hc2 && in_byte <= 8'hf4) begin
               nxt.seq_len        = (in_byte <= 8'hdf) ? 3'd2 :
                                    (in_byte <= 8'hef) ? 3'd3 : 3'd4;
               nxt.utf8_bytes     = {16'h0000, in_byte};
               nxt.utf8_remaining = 2'(nxt.seq_len - 3'd1);
               nxt.mode           = jsd_pkg::MODE_U8_SECOND;
            end else begin
               has_status = 1'b1;
               st_kind    = jsd_pkg::KIND_ERROR;
               st_err     = jsd_pkg::ERR_UTF8;
            end
         end
         jsd_pkg::MODE_ESC: begin
            nxt.mode = jsd_pkg::MODE_BODY;
            nb       = 3'd1;
            priority if (in_byte == jsd_pkg::CHAR_QUOTE ||
                         in_byte == jsd_pkg::CHAR_BSLASH ||
                         in_byte == jsd_pkg::CHAR_SLASH) begin
               cand[0] = in_byte;
            end else if (in_byte == jsd_pkg::CHAR_B) begin
               cand[0] = 8'h08;
            end else if (in_byte == jsd_pkg::CHAR_F) begin
               cand[0] = 8'h0c;
            end else if (in_byte == jsd_pkg::CHAR_N) begin
               cand[0] = 8'h0a;
            end else if (in_byte == jsd_pkg::CHAR_R) begin
               cand[0] = 8'h0d;
            end else if (in_byte == jsd_pkg::CHAR_T) begin
               cand[0] = 8'h09;
            end else if (in_byte == jsd_pkg::CHAR_U) begin
               nb            = 3'd0;
               nxt.hex_accum = '0;
               nxt.hex_count = '0;
               nxt.mode      = jsd_pkg::MODE_HEX1;
            end else begin
               nb         = 3'd0;
               has_status = 1'b1;
               st_kind    = jsd_pkg::KIND_ERROR;
               st_err     = jsd_pkg::ERR_MALFORMED;
            end
         end
         jsd_pkg::MODE_HEX1, jsd_pkg::MODE_HEX2: begin
            if (!hv[4]) begin
               has_status = 1'b1;
               st_kind    = jsd_pkg::KIND_ERROR;
               st_err     = jsd_pkg::ERR_MALFORMED;
            end else begin
               nxt.hex_accum = acc_next;
               if (!hex_done) begin
                  nxt.hex_count = st.hex_count + 2'd1;
               end else if (st.mode == jsd_pkg::MODE_HEX2) begin
                  // second half of a pair: must be a low surrogate
                  if (acc_next[15:10] != 6'b110111) begin
                     has_status = 1'b1;
                     st_kind    = jsd_pkg::KIND_ERROR;
                     st_err     = jsd_pkg::ERR_UTF8;
                  end else begin
                     cand[0]  = {5'b11110, cp21[20:18]};
                     cand[1]  = {2'b10, cp21[17:12]};
                     cand[2]  = {2'b10, cp21[11:6]};
                     cand[3]  = {2'b10, cp21[5:0]};
                     nb       = 3'd4;
                     nxt.mode = jsd_pkg::MODE_BODY;
                  end
               end else if (acc_next[15:10] == 6'b110110) begin
                  nxt.high_surrogate = acc_next[9:0];
                  nxt.mode           = jsd_pkg::MODE_SURR_BS;
               end else if (acc_next[15:10] == 6'b110111) begin
                  has_status = 1'b1;
                  st_kind    = jsd_pkg::KIND_ERROR;
                  st_err     = jsd_pkg::ERR_UTF8;
               end else begin
                  nxt.mode = jsd_pkg::MODE_BODY;
                  priority if (acc_next <= 16'h007f) begin
                     cand[0] = acc_next[7:0];
                     nb      = 3'd1;
                  end else if (acc_next <= 16'h07ff) begin
                     cand[0] = {3'b110, acc_next[10:6]};
                     cand[1] = {2'b10, acc_next[5:0]};
                     nb      = 3'd2;
                  end else begin
                     cand[0] = {4'b1110, acc_next[15:12]};
                     cand[1] = {2'b10, acc_next[11:6]};
                     cand[2] = {2'b10, acc_next[5:0]};
                     nb      = 3'd3;
                  end
               end
            end
         end
         jsd_pkg::MODE_SURR_BS: begin
            if (in_byte == jsd_pkg::CHAR_BSLASH) begin
               nxt.mode = jsd_pkg::MODE_SURR_U;
            end else begin
               has_status = 1'b1;
               st_kind    = jsd_pkg::KIND_ERROR;
               st_err     = jsd_pkg::ERR_UTF8;
            end
         end
         jsd_pkg::MODE_SURR_U: begin
            if (in_byte == jsd_pkg::CHAR_U) begin
               nxt.hex_accum = '0;
               nxt.hex_count = '0;
               nxt.mode      = jsd_pkg::MODE_HEX2;
            end else begin
               has_status = 1'b1;
               st_kind    = jsd_pkg::KIND_ERROR;
               st_err     = jsd_pkg::ERR_UTF8;
            end
         end
         jsd_pkg::MODE_U8_SECOND: begin
            if (in_byte < lo_bound || in_byte > hi_bound) begin
               has_status = 1'b1;
               st_kind    = jsd_pkg::KIND_ERROR;
               st_err     = jsd_pkg::ERR_UTF8;
            end else if (st.seq_len <= 3'd2) begin
               cand[0]            = lead;
               cand[1]            = in_byte;
               nb                 = 3'd2;
               nxt.utf8_remaining = '0;
               nxt.mode           = jsd_pkg::MODE_BODY;
            end else begin
               nxt.utf8_bytes     = {st.utf8_bytes[15:0], in_byte};
               nxt.utf8_remaining = 2'(st.seq_len - 3'd2);
               nxt.mode           = jsd_pkg::MODE_U8_REST;
            end
         end
         jsd_pkg::MODE_U8_REST: begin
            if (in_byte[7:6] != 2'b10) begin
               has_status = 1'b1;
               st_kind    = jsd_pkg::KIND_ERROR;
               st_err     = jsd_pkg::ERR_UTF8;
            end else if (st.utf8_remaining <= 2'd1) begin
               if (st.seq_len == 3'd4) begin
                  cand[0] = st.utf8_bytes[23:16];
                  cand[1] = st.utf8_bytes[15:8];
                  cand[2] = st.utf8_bytes[7:0];
                  cand[3] = in_byte;
                  nb      = 3'd4;
               end else begin
                  cand[0] = st.utf8_bytes[15:8];
                  cand[1] = st.utf8_bytes[7:0];
                  cand[2] = in_byte;
                  nb      = 3'd3;
               end
               nxt.utf8_remaining = '0;
               nxt.mode           = jsd_pkg::MODE_BODY;
            end else begin
               nxt.utf8_bytes     = {st.utf8_bytes[15:0], in_byte};
               nxt.utf8_remaining = st.utf8_remaining - 2'd1;
            end
         end
         jsd_pkg::MODE_DONE: begin
         end
         default: begin
         end
      endcase

      if (has_status) begin
         nxt.mode = jsd_pkg::MODE_DONE;
      end

      // early end of input with the string still open
      if (final_flag && nxt.mode != jsd_pkg::MODE_DONE) begin
         has_status = 1'b1;
         st_kind    = jsd_pkg::KIND_ERROR;
         if (nxt.mode == jsd_pkg::MODE_SURR_BS || nxt.mode == jsd_pkg::MODE_SURR_U ||
             nxt.mode == jsd_pkg::MODE_U8_SECOND || nxt.mode == jsd_pkg::MODE_U8_REST) begin
            st_err = jsd_pkg::ERR_UTF8;
         end else begin
            st_err = jsd_pkg::ERR_MALFORMED;
         end
         nxt.mode = jsd_pkg::MODE_DONE;
      end

      // bytes past capacity are dropped but still flag truncation
      room = jsd_pkg::LEN_W'(jsd_pkg::STRING_CAPACITY) - st.byte_count;
      if ({{(jsd_pkg::LEN_W - 3){1'b0}}, nb} > room) begin
         emit      = room[2:0];
         nxt.trunc = 1'b1;
      end else begin
         emit = nb;
      end
      nxt.byte_count = st.byte_count + jsd_pkg::LEN_W'(emit);
      for (int i = 0; i < jsd_pkg::MAX_BYTES; i++) begin
         if (3'(i) < nb && cand[i] == 8'h00) begin
            nxt.null_seen = 1'b1;
         end
      end

      for (int i = 0; i < jsd_pkg::MAX_RESULTS; i++) begin
         results[i]      = '0;
         results[i].kind = jsd_pkg::KIND_BYTE;
         results[i].err  = jsd_pkg::ERR_NONE;
      end
      for (int i = 0; i < jsd_pkg::MAX_BYTES; i++) begin
         if (3'(i) < emit) begin
            results[i].data = cand[i];
         end
      end
      if (has_status) begin
         results[emit].kind      = st_kind;
         results[emit].err       = st_err;
         results[emit].length    = nxt.byte_count;
         results[emit].trunc     = nxt.trunc;
         results[emit].null_seen = nxt.null_seen;
      end
      cnt = jsd_pkg::RES_IDX_W'(emit) + jsd_pkg::RES_IDX_W'(has_status);
      if (cnt != '0) begin
         results[cnt - 1'b1].last = 1'b1;
      end
      result_count = cnt;
      next_state   = nxt;
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for json_string_decoder_unit: directed tokens, random tokens and
// a long receiver hold-off, checked against a built-in decoder predictor.
// Depends on jsd_pkg and the json_string_decoder_unit RTL.
module tb_top;

   // Run limits: the slowest legal run is far below the cycle limit.
   localparam int RANDOM_ITEMS  = 280;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PRINT_LIMIT   = 60;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_in_byte = '0;
   logic                req_start_flag = 1'b0;
   logic                req_final_flag = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_result_kind;
   logic [7:0]          rsp_out_byte;
   logic [1:0]          rsp_error_kind;
   logic [jsd_pkg::LEN_W-1:0] rsp_decoded_length;
   logic                rsp_was_truncated;
   logic                rsp_saw_null;
   logic                rsp_last_of_run;

   json_string_decoder_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_start_flag     (req_start_flag),
      .req_final_flag     (req_final_flag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_error_kind     (rsp_error_kind),
      .rsp_decoded_length (rsp_decoded_length),
      .rsp_was_truncated  (rsp_was_truncated),
      .rsp_saw_null       (rsp_saw_null),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder predictor state: a private copy of what the block tracks.
   // ------------------------------------------------------------------
   jsd_pkg::mode_type         dec_mode;
   logic [15:0]               hex_acc;
   logic [1:0]                hex_cnt;
   logic [9:0]                hi_surr;
   logic [23:0]               seq_bytes;
   logic [1:0]                seq_left;
   logic [2:0]                seq_total;
   logic [jsd_pkg::LEN_W-1:0] out_count;
   bit                        over_cap;
   bit                        null_flag;

   // results of the item being predicted, then the queue of awaited results
   jsd_pkg::result_type step_res [jsd_pkg::MAX_RESULTS];
   int                  step_n;
   jsd_pkg::result_type awaited_results [$];

   int               mismatches   = 0;
   int               results_seen = 0;
   int               live_items   = 0;
   int               cycle_count  = 0;

   // idling switch shared by both sides; the hold-off runs in its own process
   bit               idle_on      = 1'b1;
   bit               hold_request = 1'b0;
   int               hold_left    = 0;
   int               stall_left   = 0;

   // token under construction
   logic [7:0]       tok [$];
   bit               tok_start;
   int               tok_final;

   logic [7:0] escape_letters [8] = '{jsd_pkg::CHAR_QUOTE, jsd_pkg::CHAR_BSLASH,
                                      jsd_pkg::CHAR_SLASH, jsd_pkg::CHAR_B,
                                      jsd_pkg::CHAR_F, jsd_pkg::CHAR_N,
                                      jsd_pkg::CHAR_R, jsd_pkg::CHAR_T};
   logic [15:0] bmp_corners [8] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
                                    16'h0800, 16'hd7ff, 16'he000, 16'hffff};

   function automatic void clear_decoder();
      dec_mode  = jsd_pkg::MODE_IDLE;
      hex_acc   = '0;
      hex_cnt   = '0;
      hi_surr   = '0;
      seq_bytes = '0;
      seq_left  = '0;
      seq_total = '0;
      out_count = '0;
      over_cap  = 1'b0;
      null_flag = 1'b0;
   endfunction

   // Queue one result of the current item; status fields only ride on status results.
   function automatic void emit_result(jsd_pkg::kind_type k, logic [7:0] d,
                                       jsd_pkg::err_type e);
      jsd_pkg::result_type r;
      r.kind      = k;
      r.data      = d;
      r.err       = e;
      r.length    = (k != jsd_pkg::KIND_BYTE) ? out_count : '0;
      r.trunc     = (k != jsd_pkg::KIND_BYTE) && over_cap;
      r.null_seen = (k != jsd_pkg::KIND_BYTE) && null_flag;
      r.last      = 1'b0;
      if (step_n < jsd_pkg::MAX_RESULTS) begin
         step_res[step_n] = r;
         step_n++;
      end
   endfunction

   // Bytes past capacity are dropped but still mark truncation and null.
   function automatic void push_decoded(logic [7:0] d);
      if (d == 8'h00) null_flag = 1'b1;
      if (out_count < jsd_pkg::STRING_CAPACITY) begin
         emit_result(jsd_pkg::KIND_BYTE, d, jsd_pkg::ERR_NONE);
         out_count++;
      end else begin
         over_cap = 1'b1;
      end
   endfunction

   function automatic void push_code_point(int cp);
      if (cp <= 'h7f) begin
         push_decoded(8'(cp));
      end else if (cp <= 'h7ff) begin
         push_decoded(8'(32'hc0 | (cp >> 6)));
         push_decoded(8'(32'h80 | (cp & 'h3f)));
      end else if (cp <= 'hffff) begin
         push_decoded(8'(32'he0 | (cp >> 12)));
         push_decoded(8'(32'h80 | ((cp >> 6) & 'h3f)));
         push_decoded(8'(32'h80 | (cp & 'h3f)));
      end else begin
         push_decoded(8'(32'hf0 | ((cp >> 18) & 'h07)));
         push_decoded(8'(32'h80 | ((cp >> 12) & 'h3f)));
         push_decoded(8'(32'h80 | ((cp >> 6) & 'h3f)));
         push_decoded(8'(32'h80 | (cp & 'h3f)));
      end
   endfunction

   function automatic void close_token(jsd_pkg::kind_type k, jsd_pkg::err_type e);
      emit_result(k, 8'h00, e);
      dec_mode = jsd_pkg::MODE_DONE;
   endfunction

   function automatic int hex_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
   endfunction

   // Accumulate one hex digit; true once the fourth digit is in.
   function automatic bit take_hex_digit(logic [7:0] c);
      int v;
      v = hex_value(c);
      if (v < 0) begin
         close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_MALFORMED);
         return 1'b0;
      end
      hex_acc = {hex_acc[11:0], 4'(v)};
      if (hex_cnt == 2'd3) return 1'b1;
      hex_cnt++;
      return 1'b0;
   endfunction

   function automatic void body_char(logic [7:0] b);
      if (b == jsd_pkg::CHAR_QUOTE) begin
         close_token(jsd_pkg::KIND_CLOSED, jsd_pkg::ERR_NONE);
      end else if (b == jsd_pkg::CHAR_BSLASH) begin
         dec_mode = jsd_pkg::MODE_ESC;
      end else if (b < 8'h20) begin
         close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_MALFORMED);
      end else if (b < 8'h80) begin
         push_decoded(b);
      end else if (b >= 8'hc2 && b <= 8'hf4) begin
         seq_total = (b <= 8'hdf) ? 3'd2 : (b <= 8'hef) ? 3'd3 : 3'd4;
         seq_bytes = {16'h0000, b};
         seq_left  = 2'(seq_total - 3'd1);
         dec_mode  = jsd_pkg::MODE_U8_SECOND;
      end else begin
         close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_UTF8);
      end
   endfunction

   // Predict the results of one accepted item and queue them.
   // Returns false when the item is ignored (token already closed, no start).
   function automatic bit predict_item(logic [7:0] b, bit start_bit, bit final_bit);
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      bit         live;
      int         cp;
      int         i;
      step_n = 0;
      if (start_bit) clear_decoder();
      live = (dec_mode != jsd_pkg::MODE_DONE);
      case (dec_mode)
         jsd_pkg::MODE_IDLE: begin
            if (b == jsd_pkg::CHAR_QUOTE) dec_mode = jsd_pkg::MODE_BODY;
            else close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_MALFORMED);
         end
         jsd_pkg::MODE_BODY: body_char(b);
         jsd_pkg::MODE_ESC: begin
            dec_mode = jsd_pkg::MODE_BODY;
            case (b)
               jsd_pkg::CHAR_QUOTE, jsd_pkg::CHAR_BSLASH, jsd_pkg::CHAR_SLASH:
                  push_decoded(b);
               jsd_pkg::CHAR_B: push_decoded(8'h08);
               jsd_pkg::CHAR_F: push_decoded(8'h0c);
               jsd_pkg::CHAR_N: push_decoded(8'h0a);
               jsd_pkg::CHAR_R: push_decoded(8'h0d);
               jsd_pkg::CHAR_T: push_decoded(8'h09);
               jsd_pkg::CHAR_U: begin
                  hex_acc  = '0;
                  hex_cnt  = '0;
                  dec_mode = jsd_pkg::MODE_HEX1;
               end
               default: close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_MALFORMED);
            endcase
         end
         jsd_pkg::MODE_HEX1: begin
            if (take_hex_digit(b)) begin
               if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                  hi_surr  = 10'(hex_acc - 16'hd800);
                  dec_mode = jsd_pkg::MODE_SURR_BS;
               end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                  close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_UTF8);
               end else begin
                  push_code_point(int'(hex_acc));
                  dec_mode = jsd_pkg::MODE_BODY;
               end
            end
         end
         jsd_pkg::MODE_SURR_BS: begin
            if (b == jsd_pkg::CHAR_BSLASH) dec_mode = jsd_pkg::MODE_SURR_U;
            else close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_UTF8);
         end
         jsd_pkg::MODE_SURR_U: begin
            if (b == jsd_pkg::CHAR_U) begin
               hex_acc  = '0;
               hex_cnt  = '0;
               dec_mode = jsd_pkg::MODE_HEX2;
            end else begin
               close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_UTF8);
            end
         end
         jsd_pkg::MODE_HEX2: begin
            if (take_hex_digit(b)) begin
               if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                  close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_UTF8);
               end else begin
                  cp = 'h10000 + (int'(hi_surr) << 10) + (int'(hex_acc) - 'hdc00);
                  push_code_point(cp);
                  dec_mode = jsd_pkg::MODE_BODY;
               end
            end
         end
         jsd_pkg::MODE_U8_SECOND: begin
            // second byte has tighter bounds after E0, ED, F0 and F4
            lead = seq_bytes[7:0];
            lo   = 8'h80;
            hi   = 8'hbf;
            if (lead == 8'he0) lo = 8'ha0;
            else if (lead == 8'hed) hi = 8'h9f;
            else if (lead == 8'hf0) lo = 8'h90;
            else if (lead == 8'hf4) hi = 8'h8f;
            if (b < lo || b > hi) begin
               close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_UTF8);
            end else if (seq_total <= 3'd2) begin
               push_decoded(lead);
               push_decoded(b);
               seq_left = '0;
               dec_mode = jsd_pkg::MODE_BODY;
            end else begin
               seq_bytes = {seq_bytes[15:0], b};
               seq_left  = 2'(seq_total - 3'd2);
               dec_mode  = jsd_pkg::MODE_U8_REST;
            end
         end
         jsd_pkg::MODE_U8_REST: begin
            if (b < 8'h80 || b > 8'hbf) begin
               close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_UTF8);
            end else if (seq_left <= 2'd1) begin
               for (i = int'(seq_total) - 2; i >= 0; i--)
                  push_decoded(8'(seq_bytes >> (8 * i)));
               push_decoded(b);
               seq_left = '0;
               dec_mode = jsd_pkg::MODE_BODY;
            end else begin
               seq_bytes = {seq_bytes[15:0], b};
               seq_left--;
            end
         end
         default: ;
      endcase
      // end of input with the string still open
      if (final_bit && dec_mode != jsd_pkg::MODE_DONE) begin
         if (dec_mode == jsd_pkg::MODE_SURR_BS || dec_mode == jsd_pkg::MODE_SURR_U ||
             dec_mode == jsd_pkg::MODE_U8_SECOND || dec_mode == jsd_pkg::MODE_U8_REST)
            close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_UTF8);
         else
            close_token(jsd_pkg::KIND_ERROR, jsd_pkg::ERR_MALFORMED);
      end
      if (step_n > 0) step_res[step_n - 1].last = 1'b1;
      for (i = 0; i < step_n; i++) awaited_results.push_back(step_res[i]);
      return live;
   endfunction

   // ------------------------------------------------------------------
   // Idling: mostly short gaps, a few long ones, none while idle_on is low.
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Receiver: a requested hold-off wins, otherwise random stall bursts.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checking: compare each accepted result with the oldest one awaited.
   // ------------------------------------------------------------------
   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0d] result %0d: %s", cycle_count, results_seen, msg);
   endtask

   always @(posedge clock) begin
      jsd_pkg::result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result, kind %0d byte %02h",
                                    rsp_result_kind, rsp_out_byte));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_result_kind !== want.kind)
               note_mismatch($sformatf("kind %0d, want %0d", rsp_result_kind, want.kind));
            if (rsp_out_byte !== want.data)
               note_mismatch($sformatf("byte %02h, want %02h", rsp_out_byte, want.data));
            if (rsp_error_kind !== want.err)
               note_mismatch($sformatf("error %0d, want %0d", rsp_error_kind, want.err));
            if (rsp_decoded_length !== want.length)
               note_mismatch($sformatf("length %0d, want %0d",
                                       rsp_decoded_length, want.length));
            if (rsp_was_truncated !== want.trunc)
               note_mismatch($sformatf("truncated %0b, want %0b",
                                       rsp_was_truncated, want.trunc));
            if (rsp_saw_null !== want.null_seen)
               note_mismatch($sformatf("null seen %0b, want %0b", rsp_saw_null, want.null_seen));
            if (rsp_last_of_run !== want.last)
               note_mismatch($sformatf("last %0b, want %0b", rsp_last_of_run, want.last));
         end
         results_seen++;
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("json_string_decoder_unit verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sender: optional idle gap, then offer the item and hold it until taken.
   // Inputs change on the falling edge only; valid is never dropped and
   // raised at the same edge.
   // ------------------------------------------------------------------
   task automatic send_item(input logic [7:0] value, input bit start_bit, input bit final_bit);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_in_byte    <= value;
      req_start_flag <= start_bit;
      req_final_flag <= final_bit;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (predict_item(value, start_bit, final_bit)) live_items++;
   endtask

   task automatic send_token();
      for (int i = 0; i < tok.size(); i++)
         send_item(tok[i], tok_start && i == 0, i == tok_final);
   endtask

   // ------------------------------------------------------------------
   // Token building blocks
   // ------------------------------------------------------------------
   function automatic void begin_token();
      tok.delete();
      tok_start = 1'b1;
      tok_final = -1;
      tok.push_back(jsd_pkg::CHAR_QUOTE);
   endfunction

   // printable ASCII other than quote and backslash, DEL included
   function automatic void add_text();
      logic [7:0] c;
      c = 8'($urandom_range(8'h20, 8'h7f));
      if (c == jsd_pkg::CHAR_QUOTE || c == jsd_pkg::CHAR_BSLASH) c = c + 8'd1;
      tok.push_back(c);
   endfunction

   function automatic void add_simple_escape();
      tok.push_back(jsd_pkg::CHAR_BSLASH);
      tok.push_back(escape_letters[3'($urandom_range(0, 7))]);
   endfunction

   // hex letters come in either case
   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   function automatic void add_u_escape(logic [15:0] v);
      tok.push_back(jsd_pkg::CHAR_BSLASH);
      tok.push_back(jsd_pkg::CHAR_U);
      tok.push_back(hex_char(v[15:12]));
      tok.push_back(hex_char(v[11:8]));
      tok.push_back(hex_char(v[7:4]));
      tok.push_back(hex_char(v[3:0]));
   endfunction

   function automatic logic [15:0] pick_bmp();
      case ($urandom_range(0, 4))
         0:       return 16'($urandom_range(16'h0000, 16'h007f));
         1:       return 16'($urandom_range(16'h0080, 16'h07ff));
         2:       return 16'($urandom_range(16'h0800, 16'hd7ff));
         3:       return 16'($urandom_range(16'he000, 16'hffff));
         default: return bmp_corners[3'($urandom_range(0, 7))];
      endcase
   endfunction

   function automatic void add_pair();
      add_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
      add_u_escape(16'($urandom_range(16'hdc00, 16'hdfff)));
   endfunction

   // Well-formed raw sequence; the bounded lead bytes come up often.
   function automatic void add_raw_utf8(int len);
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hbf;
      case (len)
         2: lead = 8'($urandom_range(8'hc2, 8'hdf));
         3: lead = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 8'he0 : 8'hed)
                                        : 8'($urandom_range(8'he0, 8'hef));
         default: lead = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 8'hf0 : 8'hf4)
                                              : 8'($urandom_range(8'hf0, 8'hf4));
      endcase
      if (lead == 8'he0) lo = 8'ha0;
      else if (lead == 8'hed) hi = 8'h9f;
      else if (lead == 8'hf0) lo = 8'h90;
      else if (lead == 8'hf4) hi = 8'h8f;
      tok.push_back(lead);
      tok.push_back(8'($urandom_range(lo, hi)));
      repeat (len - 2) tok.push_back(8'($urandom_range(8'h80, 8'hbf)));
   endfunction

   function automatic void add_piece();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: add_text();
         4:          add_simple_escape();
         5, 6:       add_u_escape(pick_bmp());
         7:          add_pair();
         default:    add_raw_utf8($urandom_range(2, 4));
      endcase
   endfunction

   // Mostly well-formed strings; the rest break in one of several ways.
   function automatic void build_random_token();
      int         flaw;
      int         count;
      logic [7:0] c;
      begin_token();
      tok_start = ($urandom_range(0, 19) != 0);
      flaw = ($urandom_range(0, 99) < 70) ? -1 : $urandom_range(0, 7);
      if (flaw < 0)
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      else
         count = $urandom_range(0, 3);
      if (flaw == 7) begin
         // no opening quote
         c = 8'($urandom_range(0, 255));
         tok[0] = (c == jsd_pkg::CHAR_QUOTE) ? 8'h23 : c;
         count  = 0;
      end
      repeat (count) add_piece();
      case (flaw)
         0: tok.push_back(8'($urandom_range(0, 255)));
         1: begin
            tok.push_back(jsd_pkg::CHAR_BSLASH);
            tok.push_back(8'($urandom_range(0, 255)));
         end
         2: begin
            // short run of hex digits then an arbitrary byte
            tok.push_back(jsd_pkg::CHAR_BSLASH);
            tok.push_back(jsd_pkg::CHAR_U);
            repeat ($urandom_range(0, 3)) tok.push_back(hex_char(4'($urandom_range(0, 15))));
            tok.push_back(8'($urandom_range(0, 255)));
         end
         3: add_u_escape(16'($urandom_range(16'hdc00, 16'hdfff)));
         4: begin
            add_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
            case ($urandom_range(0, 2))
               0: tok.push_back(8'($urandom_range(0, 255)));
               1: begin
                  tok.push_back(jsd_pkg::CHAR_BSLASH);
                  tok.push_back(8'($urandom_range(0, 255)));
               end
               default: add_u_escape(16'($urandom_range(0, 16'hffff)));
            endcase
         end
         5: begin
            tok.push_back(8'($urandom_range(8'hc2, 8'hf4)));
            if ($urandom_range(0, 1)) tok.push_back(8'($urandom_range(8'h80, 8'hbf)));
            tok.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      // truncated tokens get no closing quote; broken ones may trail one
      if (flaw != 6 && (flaw < 0 || $urandom_range(0, 1))) tok.push_back(jsd_pkg::CHAR_QUOTE);
      if ($urandom_range(0, 1)) tok_final = tok.size() - 1;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      // no opening quote, then a byte that must be ignored
      send_item(8'h5a, 1'b1, 1'b0);
      send_item(8'h71, 1'b0, 1'b1);
      // highest code point through a surrogate pair, then a bad lead byte
      begin_token();
      add_u_escape(16'hdbff);
      add_u_escape(16'hdfff);
      tok.push_back(8'hff);
      tok_final = tok.size() - 1;
      send_token();
      // raw control byte
      send_item(jsd_pkg::CHAR_QUOTE, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // E0 followed by a continuation below its bound
      send_item(jsd_pkg::CHAR_QUOTE, 1'b1, 1'b0);
      send_item(8'he0, 1'b0, 1'b0);
      send_item(8'h9f, 1'b0, 1'b0);
      // input ends right after the opening quote
      send_item(jsd_pkg::CHAR_QUOTE, 1'b1, 1'b1);
      // input ends inside a raw sequence
      send_item(jsd_pkg::CHAR_QUOTE, 1'b1, 1'b0);
      send_item(8'hf0, 1'b0, 1'b1);
      // empty string
      send_item(jsd_pkg::CHAR_QUOTE, 1'b1, 1'b0);
      send_item(jsd_pkg::CHAR_QUOTE, 1'b0, 1'b1);
   endtask

   // Fill to one short of capacity, so a two-byte code point straddles the
   // limit, then push a null past it.
   task automatic test_capacity();
      begin_token();
      repeat (jsd_pkg::STRING_CAPACITY - 1) add_text();
      add_u_escape(16'h00e9);
      add_u_escape(16'h0000);
      add_text();
      tok.push_back(jsd_pkg::CHAR_QUOTE);
      tok_final = tok.size() - 1;
      send_token();
   endtask

   // Hold the receiver off while the sender offers multi-byte items back to
   // back, so the result queue fills and the input stalls.
   task automatic test_backpressure();
      idle_on      = 1'b0;
      hold_request = 1'b1;
      begin_token();
      repeat (6) add_raw_utf8(4);
      add_pair();
      add_pair();
      tok.push_back(jsd_pkg::CHAR_QUOTE);
      send_token();
      idle_on = 1'b1;
   endtask

   // Random tokens until enough live items have gone in; idling drops out
   // for a stretch every couple of hundred items.
   task automatic test_random();
      int base;
      base = live_items;
      while (live_items - base < RANDOM_ITEMS) begin
         idle_on = ((live_items - base) % 200) >= 60;
         build_random_token();
         send_token();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      clear_decoder();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_capacity();
      test_backpressure();
      test_random();

      @(negedge clock);
      req_valid <= 1'b0;
      // drain whatever is still awaited, then watch for strays
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("json_string_decoder_unit verification clean");
      else
         $display("json_string_decoder_unit verification failed");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/jsd_pkg.sv
hw/rtl/jsd_step.sv
hw/rtl/json_string_decoder_unit.sv
tb/sv/tb_top.sv
